[rtl/lin_frame_transmitter_assert.svh]
// assertion macros for the lin frame transmitter
`ifndef LIN_FRAME_TRANSMITTER_ASSERT_SVH
`define LIN_FRAME_TRANSMITTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LIN_TX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lin tx: same-cycle check failed");

// next-cycle implication, checked outside reset
`define LIN_TX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lin tx: next-cycle check failed");

`endif

[rtl/lin_tx_pkg.sv]
// shared types, constants and functions of the lin frame transmitter
package lin_tx_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned IdW   = 6;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] SyncByte  = 8'h55;
  localparam logic [ByteW-1:0] BreakByte = 8'h00;

  typedef enum logic [ModeW-1:0] {
    MODE_HEADER = 2'd0,
    MODE_RESP   = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_END    = 2'd3
  } mode_e;

  // checksum update request from the frame sequencer
  typedef struct packed {
    logic  en;
    mode_e mode;
  } cksum_ctrl_t;

  // protected identifier: id bits, p0 in bit 6, p1 in bit 7
  function automatic logic [ByteW-1:0] protected_id(input logic [IdW-1:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // eight-bit add with end-around carry
  function automatic logic [ByteW-1:0] add_carry(input logic [ByteW-1:0] s,
                                                 input logic [ByteW-1:0] d);
    logic [ByteW:0] t;
    t = {1'b0, s} + {1'b0, d};
    return t[ByteW-1:0] + {{(ByteW-1){1'b0}}, t[ByteW]};
  endfunction

endpackage

[rtl/lin_frame_transmitter.sv]
// lin frame transmitter: header, checksum and frame byte sequencing
// an item is held in the input register, its result then in the result register
// throughput: one item per cycle for response start items, and for data and end
// items while the result slot is free; a header item holds the input register while
// its three bytes are emitted, as the single result register takes one byte a cycle
// reset: asynchronous active low, clears valid flags, beat count and checksum
module lin_frame_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] frame_id, [13:6] data_byte, [15:14] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] is_break
  output logic        m_axis_tlast    // last
);
  import lin_tx_pkg::*;

  // input register
  logic             in_valid_d, in_valid_q;
  mode_e            in_mode_d, in_mode_q;
  logic [IdW-1:0]   in_id_d, in_id_q;
  logic [ByteW-1:0] in_data_d, in_data_q;

  // beat within a header: 0 break, 1 sync, 2 protected identifier
  logic [1:0]       beat_d, beat_q;

  // result register
  logic             out_valid_d, out_valid_q;
  logic [ByteW-1:0] out_byte_d, out_byte_q;
  logic             out_brk_d, out_brk_q;
  logic             out_last_d, out_last_q;

  logic             out_free;
  logic             step;
  logic             done;
  logic             in_take;
  logic [ByteW-1:0] sum;
  cksum_ctrl_t      cksum_ctrl;

  // the result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  // a response start makes no result, so it never waits for the slot
  assign step = in_valid_q && ((in_mode_q == MODE_RESP) || out_free);
  assign done = step && ((in_mode_q != MODE_HEADER) || (beat_q == 2'd2));

  assign s_axis_tready = !in_valid_q || done;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register next state
  always_comb begin
    in_valid_d = in_valid_q;
    in_mode_d  = in_mode_q;
    in_id_d    = in_id_q;
    in_data_d  = in_data_q;
    if (done) begin
      in_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
      in_mode_d  = mode_e'(s_axis_tuser);
      in_id_d    = s_axis_tdata[IdW-1:0];
      in_data_d  = s_axis_tdata[IdW +: ByteW];
    end
  end

  // header beat counter
  always_comb begin
    beat_d = beat_q;
    if (step && (in_mode_q == MODE_HEADER)) begin
      beat_d = done ? 2'd0 : beat_q + 2'd1;
    end
  end

  // result register next state
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_brk_d   = out_brk_q;
    out_last_d  = out_last_q;
    if (step && (in_mode_q != MODE_RESP)) begin
      out_valid_d = 1'b1;
      out_brk_d   = 1'b0;
      out_last_d  = 1'b1;
      unique case (in_mode_q)
        MODE_HEADER: begin
          unique case (beat_q)
            2'd0: begin
              out_byte_d = BreakByte;
              out_brk_d  = 1'b1;
              out_last_d = 1'b0;
            end
            2'd1: begin
              out_byte_d = SyncByte;
              out_last_d = 1'b0;
            end
            default: out_byte_d = protected_id(in_id_q);
          endcase
        end
        MODE_DATA: out_byte_d = in_data_q;
        MODE_END:  out_byte_d = ~sum;
        default:   out_byte_d = in_data_q;
      endcase
    end
  end

  // checksum moves when an item leaves the input register, so an end item
  // always sees the sum as updated by every item ahead of it
  assign cksum_ctrl.en   = done;
  assign cksum_ctrl.mode = in_mode_q;

  lin_tx_cksum u_cksum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cksum_ctrl),
    .frame_id_i  (in_id_q),
    .data_byte_i (in_data_q),
    .sum_o       (sum)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      beat_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    in_mode_q  <= in_mode_d;
    in_id_q    <= in_id_d;
    in_data_q  <= in_data_d;
    out_byte_q <= out_byte_d;
    out_brk_q  <= out_brk_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_brk_q;
  assign m_axis_tlast  = out_last_q;

  `include "lin_frame_transmitter_assert.svh"

  // header beat never runs past the identifier byte
  `LIN_TX_ASSERT_NOW(a_beat_range, 1'b1, beat_q != 2'd3)
  // a beat in flight belongs to a held header item
  `LIN_TX_ASSERT_NOW(a_beat_header, beat_q != 2'd0, in_valid_q && (in_mode_q == MODE_HEADER))
  // a break is never the end of a header
  `LIN_TX_ASSERT_NOW(a_break_not_last, out_valid_q && out_brk_q, !out_last_q)
  // the sync byte follows a delivered break at once
  `LIN_TX_ASSERT_NEXT(a_sync_after_break, out_valid_q && out_brk_q && m_axis_tready,
                      out_valid_q && !out_brk_q && (out_byte_q == SyncByte))

endmodule

[rtl/lin_tx_cksum.sv]
// checksum accumulator of the lin frame transmitter
module lin_tx_cksum (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lin_tx_pkg::cksum_ctrl_t  ctrl_i,
  input  logic [5:0]               frame_id_i,
  input  logic [7:0]               data_byte_i,
  output logic [7:0]               sum_o
);
  import lin_tx_pkg::*;

  logic [ByteW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.mode)
        MODE_HEADER: sum_d = '0;
        MODE_RESP:   sum_d = protected_id(frame_id_i);
        MODE_DATA:   sum_d = add_carry(sum_q, data_byte_i);
        MODE_END:    sum_d = sum_q;
        default:     sum_d = sum_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
